// ===== hw/rtl/asa_pkg.sv =====
// Shared types and constants for the address-space slot allocator.
// Used by every module under hw/rtl; depends on nothing.
package asa_pkg;

   localparam int unsigned SLOT_COUNT = 16;
   localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);
   localparam int unsigned ID_W       = 4;
   localparam int unsigned ADDR_W     = 28;
   localparam int unsigned BASE_W     = 27;
   localparam int unsigned REF_W      = 16;
   localparam int unsigned CSR_IDX_W  = 2;

   localparam logic [REF_W-1:0]  REF_MAX     = '1;
   localparam logic [REF_W-1:0]  REF_ONE     = REF_W'(1);
   localparam logic [ADDR_W:0]   PAGE_MASK   = (ADDR_W+1)'(4095);
   localparam logic [ADDR_W-1:0] RAM_DEFAULT = ADDR_W'(128 * 1024 * 1024);

   typedef enum logic [1:0] {
      MODE_CREATE  = 2'd0,
      MODE_RETAIN  = 2'd1,
      MODE_RELEASE = 2'd2,
      MODE_SWITCH  = 2'd3
   } asa_mode_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_NO_FREE  = 3'd1,
      STAT_NO_RAM   = 3'd2,
      STAT_BAD_SLOT = 3'd3,
      STAT_NOT_USED = 3'd4,
      STAT_CURRENT  = 3'd5
   } asa_status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REGION_START = 2'd0,
      CSR_REGION_BYTES = 2'd1,
      CSR_RAM_LIMIT    = 2'd2
   } asa_csr_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } asa_state_type;

   // One slot entry as kept in the slot memory
   typedef struct packed {
      logic [REF_W-1:0]  refs;
      logic [BASE_W-1:0] base;
   } asa_entry_type;

   // Result of the lowest-free-slot search
   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] index;
   } asa_free_type;

   // Result beat, lowest field in the lowest bits
   typedef struct packed {
      logic [6:0]        pad;
      logic              freed;
      logic              remap;
      logic [ID_W-1:0]   current_slot;
      logic              current_valid;
      logic [REF_W-1:0]  ref_count;
      logic [BASE_W-1:0] region_base;
      logic [ID_W-1:0]   slot_out;
      asa_status_type    status;
   } asa_rsp_type;

endpackage

// ===== hw/rtl/asa_slot_ram.sv =====
// Slot entry memory: one write port, one read port, registered read data.
// Depends on asa_pkg for the entry type and depth.
module asa_slot_ram (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [asa_pkg::SLOT_W-1:0] wr_addr,
   input  asa_pkg::asa_entry_type wr_data,
   input  logic                  rd_en,
   input  logic [asa_pkg::SLOT_W-1:0] rd_addr,
   output asa_pkg::asa_entry_type rd_data
);
   import asa_pkg::*;

   asa_entry_type mem [SLOT_COUNT];
   asa_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/asa_free_find.sv =====
// Priority search for the lowest slot whose busy flag is clear.
// Depends on asa_pkg for the slot count and the result struct.
module asa_free_find (
   input  logic [asa_pkg::SLOT_COUNT-1:0] busy,
   output asa_pkg::asa_free_type          result
);
   import asa_pkg::*;

   always_comb begin
      result = '0;
      // scan downward so the lowest free slot wins
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!busy[i]) begin
            result.found = 1'b1;
            result.index = SLOT_W'(i);
         end
      end
   end

endmodule

// ===== hw/rtl/address_space_slot_allocator.sv =====
// Address-space slot allocator: top level with request sequencing and result register.
// Each accepted request passes through the execute state, which loads the result register and
// raises its result beat; a result held by rsp_tready stalls execute.
// A new request is taken only in IDLE, once the last one has executed, as the slot memory reads then writes.
// Synchronous active-high reset clears busy/region flags, the bump counter, the current
// space and the registers to their defaults at once; the slot memory is not swept.
module address_space_slot_allocator (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] slot_id, [7:4] zero
   input  logic [1:0]  req_tuser,   // [1:0] mode
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] status, [6:3] slot_out, [33:7] region_base, [49:34] ref_count,
   // [50] current_valid, [54:51] current_slot, [55] remap, [56] freed, [63:57] zero
   output logic [63:0] rsp_tdata,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [asa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [asa_pkg::ADDR_W-1:0]    csr_wdata
);
   import asa_pkg::*;

   // control state
   asa_state_type          state_ff, state_in;
   logic [SLOT_COUNT-1:0]  busy_ff, busy_in;
   logic [SLOT_COUNT-1:0]  has_region_ff, has_region_in;
   logic [ADDR_W-1:0]      handed_ff, handed_in;
   logic                   active_valid_ff, active_valid_in;
   logic [SLOT_W-1:0]      active_slot_ff, active_slot_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [ADDR_W-1:0]      region_start_ff;
   logic [ADDR_W:0]        region_size_ff;   // region_bytes rounded up to a page
   logic [ADDR_W-1:0]      ram_limit_ff;

   // request held across the execute cycle
   asa_mode_type           mode_ff;
   logic [ID_W-1:0]        id_ff;
   logic [SLOT_W-1:0]      tgt_ff;
   logic                   no_free_ff;
   logic [ADDR_W:0]        next_ff;          // region_start + bytes handed out
   asa_rsp_type            rsp_ff, rsp_in;

   // memory and search
   asa_free_type           free_slot;
   asa_entry_type          rd_entry;
   asa_entry_type          wr_entry;
   logic                   wr_en;
   logic                   req_accept;
   logic [SLOT_W-1:0]      rd_addr;
   logic                   region_grant;

   // bump arithmetic
   logic [ADDR_W+1:0]      bump_end;
   logic                   bump_fail;
   logic [ADDR_W-1:0]      handed_sum;

   asa_free_find u_free_find (
      .busy   (busy_ff),
      .result (free_slot)
   );

   asa_slot_ram u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tgt_ff),
      .wr_data (wr_entry),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // take no beat while reset is held
   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // create targets the lowest free slot; the others address slot_id
   assign rd_addr = (asa_mode_type'(req_tuser) == MODE_CREATE) ? free_slot.index
                                                                : SLOT_W'(req_tdata[ID_W-1:0]);

   assign bump_end   = {1'b0, next_ff} + {1'b0, region_size_ff};
   assign bump_fail  = bump_end > (ADDR_W+2)'(ram_limit_ff);
   assign handed_sum = handed_ff + region_size_ff[ADDR_W-1:0];

   // registers: round region_bytes up to a whole page on write
   always_ff @(posedge clock) begin
      if (reset) begin
         region_start_ff <= '0;
         region_size_ff  <= '0;
         ram_limit_ff    <= RAM_DEFAULT;
      end else if (csr_valid && csr_ready) begin
         unique case (asa_csr_type'(csr_index))
            CSR_REGION_START: region_start_ff <= csr_wdata;
            CSR_REGION_BYTES: region_size_ff  <= ({1'b0, csr_wdata} + PAGE_MASK) & ~PAGE_MASK;
            CSR_RAM_LIMIT:    ram_limit_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // latch the request and the bump start while the memory read is in flight
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff    <= asa_mode_type'(req_tuser);
         id_ff      <= req_tdata[ID_W-1:0];
         tgt_ff     <= rd_addr;
         no_free_ff <= !free_slot.found;
         next_ff    <= {1'b0, region_start_ff} + {1'b0, handed_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         busy_ff         <= '0;
         has_region_ff   <= '0;
         handed_ff       <= '0;
         active_valid_ff <= 1'b0;
         active_slot_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         busy_ff         <= busy_in;
         has_region_ff   <= has_region_in;
         handed_ff       <= handed_in;
         active_valid_ff <= active_valid_in;
         active_slot_ff  <= active_slot_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // sequencer: IDLE issues the read, EXEC builds the result and writes back any changed entry
   always_comb begin
      logic              tgt_busy;
      logic              tgt_region;
      logic              bad_slot;
      logic [REF_W-1:0]  ref_now;
      logic [BASE_W-1:0] base_now;
      logic [BASE_W-1:0] base_new;
      logic [REF_W-1:0]  refs_new;
      asa_rsp_type       res;

      state_in        = state_ff;
      busy_in         = busy_ff;
      has_region_in   = has_region_ff;
      handed_in       = handed_ff;
      active_valid_in = active_valid_ff;
      active_slot_in  = active_slot_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_in          = rsp_ff;
      wr_en           = 1'b0;
      wr_entry        = rd_entry;
      region_grant    = 1'b0;

      tgt_busy   = busy_ff[tgt_ff];
      tgt_region = has_region_ff[tgt_ff];
      bad_slot   = 32'(id_ff) >= SLOT_COUNT;
      // a slot that is not busy always has a zero count; never read stale memory for it
      ref_now    = tgt_busy ? rd_entry.refs : '0;
      base_now   = tgt_region ? rd_entry.base : '0;
      base_new   = tgt_region ? rd_entry.base : next_ff[BASE_W-1:0];
      refs_new   = ref_now;
      res        = '0;
      res.status = STAT_OK;
      res.slot_out = id_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // stall while the previous result is still waiting
            if (!rsp_valid_ff || rsp_tready) begin
               case (mode_ff)
                  MODE_CREATE: begin
                     if (no_free_ff) begin
                        res.status   = STAT_NO_FREE;
                        res.slot_out = '0;
                     end else if (!tgt_region && bump_fail) begin
                        res.status   = STAT_NO_RAM;
                        res.slot_out = '0;
                     end else begin
                        if (!tgt_region) begin
                           region_grant          = 1'b1;
                           has_region_in[tgt_ff] = 1'b1;
                           handed_in             = handed_sum;
                        end
                        busy_in[tgt_ff]  = 1'b1;
                        wr_en            = 1'b1;
                        wr_entry.refs    = REF_ONE;
                        wr_entry.base    = base_new;
                        res.slot_out     = ID_W'(tgt_ff);
                        res.region_base  = base_new;
                        res.ref_count    = REF_ONE;
                     end
                  end
                  default: begin
                     if (bad_slot) begin
                        res.status = STAT_BAD_SLOT;
                     end else if (!tgt_busy) begin
                        res.status      = STAT_NOT_USED;
                        res.region_base = base_now;
                     end else begin
                        res.region_base = base_now;
                        case (mode_ff)
                           MODE_RETAIN: begin
                              if (ref_now != REF_MAX) begin
                                 refs_new = ref_now + REF_ONE;
                              end
                              wr_en         = 1'b1;
                              wr_entry.refs = refs_new;
                           end
                           MODE_RELEASE: begin
                              if (ref_now != '0) begin
                                 refs_new = ref_now - REF_ONE;
                              end
                              wr_en         = 1'b1;
                              wr_entry.refs = refs_new;
                              if (refs_new == '0) begin
                                 busy_in[tgt_ff] = 1'b0;
                                 res.freed       = 1'b1;
                                 if (active_valid_ff && active_slot_ff == tgt_ff) begin
                                    active_valid_in = 1'b0;
                                    active_slot_in  = '0;
                                 end
                              end
                           end
                           default: begin
                              if (active_valid_ff && active_slot_ff == tgt_ff) begin
                                 res.status = STAT_CURRENT;
                              end else begin
                                 active_valid_in = 1'b1;
                                 active_slot_in  = tgt_ff;
                                 res.remap       = 1'b1;
                              end
                           end
                        endcase
                        res.ref_count = refs_new;
                     end
                  end
               endcase
               res.current_valid = active_valid_in;
               res.current_slot  = active_valid_in ? ID_W'(active_slot_in) : '0;
               rsp_in       = res;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   // the current space must always be a busy slot
   a_current_busy: assert property (@(posedge clock) disable iff (reset)
      active_valid_ff |-> busy_ff[active_slot_ff])
      else $error("current space points at a free slot");

   // a busy slot always owns a region
   a_busy_has_region: assert property (@(posedge clock) disable iff (reset)
      (busy_ff & ~has_region_ff) == '0)
      else $error("busy slot without a region");

   // an accepted request moves to the execute cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_EXEC)
      else $error("accepted request did not enter execute");

   // the bump counter only moves when a region is granted
   a_bump_moves: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && handed_ff != $past(handed_ff)) |-> $past(region_grant))
      else $error("bump counter moved without a region grant");

   // a memory write happens only in the execute cycle
   a_write_exec: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == ST_EXEC)
      else $error("slot memory written outside execute");
`endif

endmodule
